### hw/rtl/sabw_pkg.sv
// ---------------------------------------------------------------------------
// sabw_pkg
// Types and constants shared by the segment allocator modules.
// ---------------------------------------------------------------------------
package sabw_pkg;

	// Field widths fixed by the item formats.
	localparam int OFS_W    = 16;
	localparam int LEN_W    = 17;
	localparam int BYTES_W  = 22;
	localparam int WB_W     = 7;
	localparam int WORDS_W  = 23;
	localparam int DCNT_W   = 5;
	localparam int CIDX_W   = 2;

	// Length of a freshly reset table.
	localparam logic [LEN_W-1:0] FULL_REGION = 17'h10000;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_FIT_MODE     = 2'd0;
	localparam logic [CIDX_W-1:0] REG_WORD_BYTES   = 2'd1;
	localparam logic [CIDX_W-1:0] REG_REGION_WORDS = 2'd2;

	// Operation codes.
	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_INIT  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		RES_DONE   = 2'd0,
		RES_NOFIT  = 2'd1,
		RES_FULL   = 2'd2,
		RES_BADOFS = 2'd3
	} res_t;

	// One table entry as stored in the segment memory.
	typedef struct packed {
		logic             used;
		logic [LEN_W-1:0] len;
		logic [OFS_W-1:0] start;
	} entry_t;

	// Datapath commands issued by the controller.
	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_TAKE,
		CMD_RST_LOAD,
		CMD_TBL_LOAD,
		CMD_DIV_LOAD,
		CMD_DIV_STEP,
		CMD_WORDS,
		CMD_SCAN_LOAD,
		CMD_SCAN_STEP,
		CMD_SHUP_LOAD,
		CMD_SHUP_STEP,
		CMD_WR_TAIL,
		CMD_WR_HEAD,
		CMD_NEXT_RD,
		CMD_NEXT_CAP,
		CMD_MERGE_WR,
		CMD_SHDN_STEP,
		CMD_RESULT
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		res_t code;
	} ctl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic in_valid;
		logic bytes_zero;
		logic region_bad;
		logic div_done;
		logic scan_done;
		logic found;
		logic need_split;
		logic tbl_full;
		logic shup_done;
		logic shdn_done;
		logic merge_none;
		logic out_free;
	} dp_stat_t;

endpackage

### hw/rtl/sabw_if.sv
// ---------------------------------------------------------------------------
// sabw_if
// Channel interfaces of the segment allocator: request, response, config.
// ---------------------------------------------------------------------------
interface sabw_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [21:0] size_bytes;
	logic [15:0] free_offset;
	modport source (output valid, output op, output size_bytes, output free_offset,
		input ready);
	modport sink (input valid, input op, input size_bytes, input free_offset,
		output ready);
endinterface

interface sabw_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] word_offset;
	modport source (output valid, output status, output word_offset, input ready);
	modport sink (input valid, input status, input word_offset, output ready);
endinterface

interface sabw_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [16:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/segment_allocator_best_worst_fit_unit.sv
// ---------------------------------------------------------------------------
// segment_allocator_best_worst_fit_unit
// Word-granular segment allocator with best-fit or worst-fit placement.
// ---------------------------------------------------------------------------
// The block takes one request at a time and returns one response beat per
// request. An allocate runs the bit-serial byte-to-word divider, scans the
// table through the single read port of the segment memory, and moves
// entries one slot up when the chosen segment is split. A free scans the
// table, merges the freed segment with its free neighbors and then moves
// entries down; initialize and unknown operations go straight to the
// response. After reset the block loads the first table entry before it
// takes a request. Configuration writes are always accepted.
module segment_allocator_best_worst_fit_unit import sabw_pkg::*; #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	sabw_req_if.sink   req,
	sabw_rsp_if.source rsp,
	sabw_cfg_if.sink   cfg
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	sabw_ctl u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	sabw_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.stat   (stat),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// One request is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is in progress");

	// A result load with a free output register shows up as a response beat.
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cmd == CMD_RESULT && stat.out_free |=> rsp.valid)
		else $error("result not presented");

	// A split never grows a full table.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.cmd == CMD_WR_TAIL && stat.tbl_full))
		else $error("segment table overflow");

endmodule

### hw/rtl/sabw_ram.sv
// ---------------------------------------------------------------------------
// sabw_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sabw_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/sabw_dp.sv
// ---------------------------------------------------------------------------
// sabw_dp
// Allocator datapath: config registers, word divider, segment table memory,
// scan and shift address logic, and the result register.
// ---------------------------------------------------------------------------
module sabw_dp import sabw_pkg::*; #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctl_cmd_t   ctl,
	output dp_stat_t   stat,
	sabw_req_if.sink   req,
	sabw_rsp_if.source rsp,
	sabw_cfg_if.sink   cfg
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	// Memory port signals.
	entry_t          rdata, wdata;
	logic            we;
	logic [IW-1:0]   waddr, raddr;

	// Configuration.
	logic             fit_q;
	logic [WB_W-1:0]  wb_q;
	logic [LEN_W-1:0] region_q;

	// Item and table control.
	op_t                op_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [OFS_W-1:0]   offset_q;
	logic [CW-1:0]      count_q;

	// Divider.
	logic [BYTES_W-1:0] dvd_q;
	logic [WB_W-1:0]    rem_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic [WORDS_W-1:0] words_q;
	logic [WB_W-1:0]    divisor;
	logic [WB_W:0]      rem_sh, rem_nx;
	logic               rem_ge;

	// Scan and shift.
	logic [CW-1:0]    ra_q, wa_q;
	logic             rv_s1;
	logic [IW-1:0]    ev_s1;
	logic             found_q;
	logic [IW-1:0]    pick_q;
	logic [LEN_W-1:0] best_q;
	entry_t           pick_ent_q, prev_q, next_q;
	logic             next_ok_q;

	// Result register.
	logic             out_valid_q;
	res_t             out_status_q;
	logic [OFS_W-1:0] out_ofs_q;

	// Scan evaluation and merge arithmetic.
	logic             fits, better, prev_ok, ra_lt_cnt, shup_go;
	logic [LEN_W-1:0] left, merged_len;
	logic [IW-1:0]    p_idx;
	logic [CW-1:0]    s_idx, d_idx, r_cnt;
	entry_t           merged;

	sabw_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_SEGMENTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// One restoring division step; a word size of zero counts as one.
	always_comb begin
		divisor = (wb_q == '0) ? WB_W'(1) : wb_q;
		rem_sh  = {rem_q, dvd_q[BYTES_W-1]};
		rem_ge  = rem_sh >= {1'b0, divisor};
		rem_nx  = rem_ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
	end

	// Fit test of the entry now on the read port.
	always_comb begin
		fits   = !rdata.used && ({{(WORDS_W-LEN_W){1'b0}}, rdata.len} >= words_q);
		left   = rdata.len - words_q[LEN_W-1:0];
		better = !found_q || (fit_q ? (left > best_q) : (left < best_q));
	end

	// Merge of a freed segment with its free neighbors.
	always_comb begin
		prev_ok    = (pick_q != '0) && !prev_q.used;
		p_idx      = prev_ok ? (pick_q - IW'(1)) : pick_q;
		d_idx      = CW'(p_idx) + CW'(1);
		s_idx      = CW'(pick_q) + CW'(1) + CW'(next_ok_q);
		r_cnt      = s_idx - d_idx;
		merged_len = pick_ent_q.len + (next_ok_q ? next_q.len : '0)
			+ (prev_ok ? prev_q.len : '0);
		merged.used  = 1'b0;
		merged.len   = merged_len;
		merged.start = prev_ok ? prev_q.start : pick_ent_q.start;
		ra_lt_cnt  = ra_q < count_q;
		shup_go    = ra_q > CW'(pick_q);
	end

	// Memory address and write selection per command.
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = ra_q[IW-1:0];
		case (ctl.cmd)
			CMD_RST_LOAD: begin
				we         = 1'b1;
				wdata.len  = FULL_REGION;
			end
			CMD_TBL_LOAD: begin
				we         = 1'b1;
				wdata.len  = region_q;
			end
			CMD_SHUP_STEP: begin
				we    = rv_s1;
				waddr = ev_s1 + IW'(1);
				wdata = rdata;
			end
			CMD_WR_TAIL: begin
				we          = 1'b1;
				waddr       = pick_q + IW'(1);
				wdata.len   = pick_ent_q.len - words_q[LEN_W-1:0];
				wdata.start = pick_ent_q.start + words_q[OFS_W-1:0];
			end
			CMD_WR_HEAD: begin
				we          = 1'b1;
				waddr       = pick_q;
				wdata.used  = 1'b1;
				wdata.len   = words_q[LEN_W-1:0];
				wdata.start = pick_ent_q.start;
			end
			CMD_NEXT_RD: begin
				raddr = pick_q + IW'(1);
			end
			CMD_MERGE_WR: begin
				we    = 1'b1;
				waddr = p_idx;
				wdata = merged;
			end
			CMD_SHDN_STEP: begin
				we    = rv_s1;
				waddr = wa_q[IW-1:0];
				wdata = rdata;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Configuration writes; the port never stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q    <= 1'b0;
			wb_q     <= WB_W'(2);
			region_q <= FULL_REGION;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FIT_MODE:     fit_q    <= cfg.data[0];
				REG_WORD_BYTES:   wb_q     <= cfg.data[WB_W-1:0];
				REG_REGION_WORDS: region_q <= cfg.data;
				default:          fit_q    <= fit_q;
			endcase
		end
	end

	// Control state of the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CW'(1);
			dcnt_q      <= '0;
			ra_q        <= '0;
			wa_q        <= '0;
			rv_s1       <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (ctl.cmd)
				CMD_RST_LOAD, CMD_TBL_LOAD: begin
					count_q <= CW'(1);
				end
				CMD_DIV_LOAD: begin
					dcnt_q <= DCNT_W'(BYTES_W);
				end
				CMD_DIV_STEP: begin
					if (dcnt_q != '0) begin
						dcnt_q <= dcnt_q - DCNT_W'(1);
					end
				end
				CMD_SCAN_LOAD: begin
					ra_q    <= '0;
					rv_s1   <= 1'b0;
					found_q <= 1'b0;
				end
				CMD_SCAN_STEP: begin
					rv_s1 <= ra_lt_cnt;
					if (ra_lt_cnt) begin
						ra_q <= ra_q + CW'(1);
					end
					if (rv_s1) begin
						if (op_q == OP_FREE) begin
							if (!found_q && rdata.start == offset_q) begin
								found_q <= 1'b1;
							end
						end else if (fits && better) begin
							found_q <= 1'b1;
						end
					end
				end
				CMD_SHUP_LOAD: begin
					ra_q  <= count_q - CW'(1);
					rv_s1 <= 1'b0;
				end
				CMD_SHUP_STEP: begin
					rv_s1 <= shup_go;
					if (shup_go) begin
						ra_q <= ra_q - CW'(1);
					end
				end
				CMD_WR_TAIL: begin
					count_q <= count_q + CW'(1);
				end
				CMD_MERGE_WR: begin
					ra_q  <= s_idx;
					wa_q  <= d_idx;
					rv_s1 <= 1'b0;
				end
				CMD_SHDN_STEP: begin
					rv_s1 <= ra_lt_cnt;
					if (ra_lt_cnt) begin
						ra_q <= ra_q + CW'(1);
					end
					if (rv_s1) begin
						wa_q <= wa_q + CW'(1);
					end
					if (!ra_lt_cnt && !rv_s1) begin
						count_q <= count_q - r_cnt;
					end
				end
				CMD_RESULT: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					rv_s1 <= rv_s1;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_TAKE: begin
				if (req.valid) begin
					op_q     <= op_t'(req.op);
					bytes_q  <= req.size_bytes;
					offset_q <= req.free_offset;
				end
			end
			CMD_DIV_LOAD: begin
				dvd_q <= bytes_q;
				rem_q <= '0;
			end
			CMD_DIV_STEP: begin
				if (dcnt_q != '0) begin
					rem_q <= rem_nx[WB_W-1:0];
					dvd_q <= {dvd_q[BYTES_W-2:0], rem_ge};
				end
			end
			CMD_WORDS: begin
				words_q <= {1'b0, dvd_q} + WORDS_W'(rem_q != '0);
			end
			CMD_SCAN_STEP: begin
				ev_s1 <= ra_q[IW-1:0];
				if (rv_s1) begin
					if (op_q == OP_FREE) begin
						if (!found_q) begin
							if (rdata.start == offset_q) begin
								pick_q     <= ev_s1;
								pick_ent_q <= rdata;
							end else begin
								prev_q <= rdata;
							end
						end
					end else if (fits && better) begin
						pick_q     <= ev_s1;
						pick_ent_q <= rdata;
						best_q     <= left;
					end
				end
			end
			CMD_SHUP_STEP: begin
				ev_s1 <= ra_q[IW-1:0];
			end
			CMD_NEXT_CAP: begin
				next_q    <= rdata;
				next_ok_q <= ((CW'(pick_q) + CW'(1)) < count_q) && !rdata.used;
			end
			CMD_RESULT: begin
				if (!out_valid_q || rsp.ready) begin
					out_status_q <= ctl.code;
					out_ofs_q    <= (ctl.code == RES_DONE && op_q == OP_ALLOC) ?
						pick_ent_q.start : '0;
				end
			end
			default: begin
				ev_s1 <= ev_s1;
			end
		endcase
	end

	// Handshake outputs and status to the controller.
	always_comb begin
		req.ready       = ctl.cmd == CMD_TAKE;
		cfg.ready       = 1'b1;
		rsp.valid       = out_valid_q;
		rsp.status      = out_status_q;
		rsp.word_offset = out_ofs_q;

		stat.op         = op_q;
		stat.in_valid   = req.valid;
		stat.bytes_zero = bytes_q == '0;
		stat.region_bad = (region_q == '0) || (region_q > FULL_REGION);
		stat.div_done   = dcnt_q == '0;
		stat.scan_done  = !ra_lt_cnt && !rv_s1;
		stat.found      = found_q;
		stat.need_split = {{(WORDS_W-LEN_W){1'b0}}, pick_ent_q.len} > words_q;
		stat.tbl_full   = count_q == CW'(MAX_SEGMENTS);
		stat.shup_done  = !shup_go && !rv_s1;
		stat.shdn_done  = !ra_lt_cnt && !rv_s1;
		stat.merge_none = r_cnt == '0;
		stat.out_free   = !out_valid_q || rsp.ready;
	end

endmodule

### hw/rtl/sabw_ctl.sv
// ---------------------------------------------------------------------------
// sabw_ctl
// Allocator controller: sequences divide, scan, shift and write phases and
// picks the result code.
// ---------------------------------------------------------------------------
module sabw_ctl import sabw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_stat_t stat,
	output ctl_cmd_t ctl
);

	typedef enum logic [16:0] {
		S_RST   = 17'd1,
		S_IDLE  = 17'd2,
		S_DISP  = 17'd4,
		S_DIV   = 17'd8,
		S_WORDS = 17'd16,
		S_SCAN0 = 17'd32,
		S_SCAN  = 17'd64,
		S_ADEC  = 17'd128,
		S_SHUP0 = 17'd256,
		S_SHUP  = 17'd512,
		S_WTAIL = 17'd1024,
		S_WHEAD = 17'd2048,
		S_FRD   = 17'd4096,
		S_FCAP  = 17'd8192,
		S_FMRG  = 17'd16384,
		S_SHDN  = 17'd32768,
		S_RESP  = 17'd65536
	} state_t;

	state_t state_q, state_d;
	res_t   code_q, code_d;

	// Next state, command and result code.
	always_comb begin
		state_d  = state_q;
		code_d   = code_q;
		ctl.cmd  = CMD_NOP;
		ctl.code = code_q;
		case (state_q)
			S_RST: begin
				ctl.cmd = CMD_RST_LOAD;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				ctl.cmd = CMD_TAKE;
				if (stat.in_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.op)
					OP_ALLOC: begin
						if (stat.bytes_zero) begin
							code_d  = RES_NOFIT;
							state_d = S_RESP;
						end else begin
							ctl.cmd = CMD_DIV_LOAD;
							state_d = S_DIV;
						end
					end
					OP_FREE: begin
						state_d = S_SCAN0;
					end
					OP_INIT: begin
						if (stat.region_bad) begin
							code_d = RES_NOFIT;
						end else begin
							ctl.cmd = CMD_TBL_LOAD;
							code_d  = RES_DONE;
						end
						state_d = S_RESP;
					end
					default: begin
						code_d  = RES_DONE;
						state_d = S_RESP;
					end
				endcase
			end
			S_DIV: begin
				ctl.cmd = CMD_DIV_STEP;
				if (stat.div_done) begin
					state_d = S_WORDS;
				end
			end
			S_WORDS: begin
				ctl.cmd = CMD_WORDS;
				state_d = S_SCAN0;
			end
			S_SCAN0: begin
				ctl.cmd = CMD_SCAN_LOAD;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				ctl.cmd = CMD_SCAN_STEP;
				if (stat.scan_done) begin
					if (stat.op == OP_ALLOC) begin
						state_d = S_ADEC;
					end else if (stat.found) begin
						state_d = S_FRD;
					end else begin
						code_d  = RES_BADOFS;
						state_d = S_RESP;
					end
				end
			end
			// Allocation decision after the scan.
			S_ADEC: begin
				if (!stat.found) begin
					code_d  = RES_NOFIT;
					state_d = S_RESP;
				end else if (!stat.need_split) begin
					state_d = S_WHEAD;
				end else if (stat.tbl_full) begin
					code_d  = RES_FULL;
					state_d = S_RESP;
				end else begin
					state_d = S_SHUP0;
				end
			end
			S_SHUP0: begin
				ctl.cmd = CMD_SHUP_LOAD;
				state_d = S_SHUP;
			end
			S_SHUP: begin
				ctl.cmd = CMD_SHUP_STEP;
				if (stat.shup_done) begin
					state_d = S_WTAIL;
				end
			end
			S_WTAIL: begin
				ctl.cmd = CMD_WR_TAIL;
				state_d = S_WHEAD;
			end
			S_WHEAD: begin
				ctl.cmd = CMD_WR_HEAD;
				code_d  = RES_DONE;
				state_d = S_RESP;
			end
			S_FRD: begin
				ctl.cmd = CMD_NEXT_RD;
				state_d = S_FCAP;
			end
			S_FCAP: begin
				ctl.cmd = CMD_NEXT_CAP;
				state_d = S_FMRG;
			end
			S_FMRG: begin
				ctl.cmd = CMD_MERGE_WR;
				code_d  = RES_DONE;
				state_d = stat.merge_none ? S_RESP : S_SHDN;
			end
			S_SHDN: begin
				ctl.cmd = CMD_SHDN_STEP;
				if (stat.shdn_done) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				ctl.cmd = CMD_RESULT;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_RST;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RST;
			code_q  <= RES_DONE;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule
